>>> hw/rtl/mst_pkg.sv
// Package for the Kruskal minimum spanning tree block.
// Holds field widths, result codes and the controller state type.
package mst_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 32;
  localparam int unsigned MAX_EDGES_DEF    = 256;

  localparam int unsigned VID_W    = 5;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned SUM_W    = 21;
  localparam int unsigned VCNT_W   = 6;
  localparam int unsigned EMIT_W   = 5;

  localparam int unsigned RESULT_CAP = 32;
  localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(32);

  localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W+1)'(1048575);
  localparam logic signed [SUM_W:0] SUM_MIN = -(SUM_W+1)'(1048576);

  localparam logic KIND_EDGE  = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_SCAN,
    ST_FS_RD,
    ST_FS_CHK,
    ST_FD_RD,
    ST_FD_CHK,
    ST_UNION,
    ST_TOTAL
  } state_e;

endpackage

>>> hw/rtl/minimum_spanning_tree_kruskal.sv
// Kruskal minimum spanning tree: edge store, ordered selection scan, union-find.
// Load: one item per cycle. Compute after the last item: the parent table is
// rebuilt, then per selected edge a store scan, a read and a check state per find
// step of each end, and a union state, held while a result waits;
// one further scan and the total state end the run.
// Input is stalled from the last item until the total item is registered.
// Reset clears control state and sets vc_q to 32; the edge store is not cleared.
module minimum_spanning_tree_kruskal
  import mst_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned MAX_EDGES    = MAX_EDGES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [VCNT_W-1:0]          cfg_vertex_count_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [VID_W-1:0]           edge_src_i,
  input  logic [VID_W-1:0]           edge_dst_i,
  input  logic signed [WEIGHT_W-1:0] edge_weight_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       kind_o,
  output logic [VID_W-1:0]           tree_src_o,
  output logic [VID_W-1:0]           tree_dst_o,
  output logic signed [WEIGHT_W-1:0] tree_weight_o,
  output logic signed [SUM_W-1:0]    total_weight_o,
  output logic                       dropped_o,
  output logic                       end_of_run_o
);

  localparam int unsigned VW    = $clog2(MAX_VERTICES);
  localparam int unsigned EA    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CW    = $clog2(MAX_EDGES + 1);
  localparam int unsigned NVW   = (VW + 1 > VCNT_W) ? VW + 1 : VCNT_W;
  localparam int unsigned MEM_W = 2 * VID_W + WEIGHT_W;

  state_e state_q, state_d;

  logic [VCNT_W-1:0] vc_q;
  logic [CW-1:0]     cnt_q;
  logic              drop_q;

  logic [MEM_W-1:0] edge_mem [MAX_EDGES];
  logic [MEM_W-1:0] edge_rd_q;

  logic [VW-1:0] par_mem [MAX_VERTICES];
  logic [VW-1:0] par_rd_q;

  logic [CW-1:0]  scan_cnt_q;
  logic           chk_vld_q;
  logic [EA-1:0]  chk_idx_q;
  logic           found_q;
  logic [VID_W-1:0] best_src_q, best_dst_q;
  logic signed [WEIGHT_W-1:0] best_w_q;
  logic [EA-1:0]  best_idx_q;
  logic           prev_vld_q;
  logic signed [WEIGHT_W-1:0] prev_w_q;
  logic [EA-1:0]  prev_idx_q;

  logic [VW-1:0] fv_q, root_s_q, root_d_q, clr_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [EMIT_W-1:0] emit_q;

  logic out_valid_q;
  logic kind_q, dropped_q, eor_q;
  logic [VID_W-1:0] tsrc_q, tdst_q;
  logic signed [WEIGHT_W-1:0] tw_q;
  logic signed [SUM_W-1:0] tot_q;

  logic in_acc, drop_in, issue, scan_end, out_free, union_go, join_go;
  logic emit_go, total_go;
  logic [NVW-1:0] eff_nv;
  logic [VID_W-1:0] rd_src, rd_dst;
  logic signed [WEIGHT_W-1:0] rd_w;
  logic cand, better;
  logic signed [SUM_W:0] sum_ext;
  logic signed [SUM_W-1:0] sum_sat;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_LOAD);
  assign in_acc      = in_valid_i && !in_stall_o;

  assign eff_nv  = (NVW'(vc_q) > NVW'(MAX_VERTICES)) ? NVW'(MAX_VERTICES) : NVW'(vc_q);
  assign drop_in = (NVW'(edge_src_i) >= eff_nv) || (NVW'(edge_dst_i) >= eff_nv) ||
                   (cnt_q == CW'(MAX_EDGES));

  assign issue    = (scan_cnt_q < cnt_q);
  assign scan_end = (state_q == ST_SCAN) && !issue && !chk_vld_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign union_go = (state_q == ST_UNION) && out_free;
  assign join_go  = union_go && (root_s_q != root_d_q);
  assign emit_go  = join_go && (emit_q != EMIT_W'(RESULT_CAP - 1));
  assign total_go = (state_q == ST_TOTAL) && out_free;

  assign rd_src = edge_rd_q[MEM_W-1 -: VID_W];
  assign rd_dst = edge_rd_q[WEIGHT_W +: VID_W];
  assign rd_w   = $signed(edge_rd_q[WEIGHT_W-1:0]);

  assign cand   = !prev_vld_q || (rd_w > prev_w_q) ||
                  ((rd_w == prev_w_q) && (chk_idx_q > prev_idx_q));
  assign better = !found_q || (rd_w < best_w_q);

  assign sum_ext = (SUM_W+1)'(sum_q) + (SUM_W+1)'(best_w_q);
  always_comb begin
    if (sum_ext > SUM_MAX) begin
      sum_sat = SUM_MAX[SUM_W-1:0];
    end else if (sum_ext < SUM_MIN) begin
      sum_sat = SUM_MIN[SUM_W-1:0];
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:   if (in_acc && last_i) state_d = ST_CLEAR;
      ST_CLEAR:  if (clr_q == VW'(MAX_VERTICES - 1)) state_d = ST_SCAN;
      ST_SCAN:   if (scan_end) state_d = found_q ? ST_FS_RD : ST_TOTAL;
      ST_FS_RD:  state_d = ST_FS_CHK;
      ST_FS_CHK: state_d = (par_rd_q == fv_q) ? ST_FD_RD : ST_FS_RD;
      ST_FD_RD:  state_d = ST_FD_CHK;
      ST_FD_CHK: state_d = (par_rd_q == fv_q) ? ST_UNION : ST_FD_RD;
      ST_UNION:  if (out_free) state_d = ST_SCAN;
      ST_TOTAL:  if (out_free) state_d = ST_LOAD;
      default:   state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // edge store
  always_ff @(posedge clk_i) begin
    if (in_acc && !drop_in) begin
      edge_mem[cnt_q[EA-1:0]] <= {edge_src_i, edge_dst_i, edge_weight_i};
    end
    edge_rd_q <= edge_mem[scan_cnt_q[EA-1:0]];
  end

  // parent table
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      par_mem[clr_q] <= clr_q;
    end else if (join_go) begin
      par_mem[root_d_q] <= root_s_q;
    end
    par_rd_q <= par_mem[fv_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q        <= VCNT_RESET;
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      scan_cnt_q  <= '0;
      chk_vld_q   <= 1'b0;
      chk_idx_q   <= '0;
      found_q     <= 1'b0;
      prev_vld_q  <= 1'b0;
      prev_w_q    <= '0;
      prev_idx_q  <= '0;
      best_src_q  <= '0;
      best_dst_q  <= '0;
      best_w_q    <= '0;
      best_idx_q  <= '0;
      fv_q        <= '0;
      root_s_q    <= '0;
      root_d_q    <= '0;
      clr_q       <= '0;
      sum_q       <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        vc_q <= cfg_vertex_count_i;
      end
      if (emit_go || total_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      chk_vld_q <= (state_q == ST_SCAN) && issue;
      case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (drop_in) begin
              drop_q <= 1'b1;
            end else begin
              cnt_q <= cnt_q + CW'(1);
            end
            clr_q <= '0;
          end
        end
        ST_CLEAR: begin
          clr_q      <= clr_q + VW'(1);
          sum_q      <= '0;
          emit_q     <= '0;
          prev_vld_q <= 1'b0;
          scan_cnt_q <= '0;
          found_q    <= 1'b0;
        end
        ST_SCAN: begin
          if (issue) begin
            scan_cnt_q <= scan_cnt_q + CW'(1);
          end
          chk_idx_q <= scan_cnt_q[EA-1:0];
          if (chk_vld_q && cand && better) begin
            found_q    <= 1'b1;
            best_src_q <= rd_src;
            best_dst_q <= rd_dst;
            best_w_q   <= rd_w;
            best_idx_q <= chk_idx_q;
          end
          if (scan_end) begin
            prev_vld_q <= 1'b1;
            prev_w_q   <= best_w_q;
            prev_idx_q <= best_idx_q;
            fv_q       <= VW'(best_src_q);
          end
        end
        ST_FS_CHK: begin
          if (par_rd_q == fv_q) begin
            root_s_q <= fv_q;
            fv_q     <= VW'(best_dst_q);
          end else begin
            fv_q <= par_rd_q;
          end
        end
        ST_FD_CHK: begin
          if (par_rd_q == fv_q) begin
            root_d_q <= fv_q;
          end else begin
            fv_q <= par_rd_q;
          end
        end
        ST_UNION: begin
          if (out_free) begin
            scan_cnt_q <= '0;
            found_q    <= 1'b0;
            if (join_go) begin
              sum_q <= sum_sat;
            end
            if (emit_go) begin
              emit_q <= emit_q + EMIT_W'(1);
            end
          end
        end
        ST_TOTAL: begin
          if (out_free) begin
            cnt_q  <= '0;
            drop_q <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      kind_q    <= KIND_EDGE;
      tsrc_q    <= best_src_q;
      tdst_q    <= best_dst_q;
      tw_q      <= best_w_q;
      tot_q     <= '0;
      dropped_q <= 1'b0;
      eor_q     <= 1'b0;
    end else if (total_go) begin
      kind_q    <= KIND_TOTAL;
      tsrc_q    <= '0;
      tdst_q    <= '0;
      tw_q      <= '0;
      tot_q     <= sum_q;
      dropped_q <= drop_q;
      eor_q     <= 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign tree_src_o     = tsrc_q;
  assign tree_dst_o     = tdst_q;
  assign tree_weight_o  = tw_q;
  assign total_weight_o = tot_q;
  assign dropped_o      = dropped_q;
  assign end_of_run_o   = eor_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_EDGES))
    else $error("edge count beyond store depth");

  a_emit_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (union_go && (emit_q == EMIT_W'(RESULT_CAP - 1))) |=> (emit_q == EMIT_W'(RESULT_CAP - 1)))
    else $error("tree edge counter passed its cap");

  a_total_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_TOTAL) && out_free) |=> (state_q == ST_LOAD) && out_valid_q && eor_q)
    else $error("total item did not close the run");

  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> (out_valid_o && end_of_run_o))
    else $error("input reopened without a total item");

  a_scan_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_vld_q |-> (state_q == ST_SCAN))
    else $error("store read data outside scan");

endmodule
